// ===== rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int IN_WIDTH    = 32;
   localparam int CHAR_WIDTH  = 7;
   localparam int LEN_WIDTH   = 4;
   localparam int NIBBLE      = 4;

   localparam int RADIX_DEC = 10;
   localparam int RADIX_HEX = 16;

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 7'h2D;

   // digits of the largest magnitude, 2^(VALUE_WIDTH-1)
   localparam int DEC_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_WIDTH - 1) / NIBBLE + 1;
   localparam int DIGIT_MAX  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int IDX_WIDTH  = $clog2(DIGIT_MAX);
   localparam int CNT_WIDTH  = $clog2(DIGIT_MAX + 1);

   // exact divide by ten: q = (m * DEC_RECIP) >> DEC_SHIFT
   localparam int DEC_SHIFT = VALUE_WIDTH + NIBBLE;
   localparam logic [DEC_SHIFT:0] RECIP_POW = (DEC_SHIFT + 1)'(1) << DEC_SHIFT;
   localparam logic [VALUE_WIDTH:0] DEC_RECIP =
      (VALUE_WIDTH + 1)'((RECIP_POW + (RADIX_DEC - 1)) / RADIX_DEC);

   typedef struct packed {
      logic load;
      logic step;
      logic put_sign;
      logic put_digit;
   } itoa_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic negative;
      logic digit_last;
      logic out_free;
   } itoa_sts_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [NIBBLE-1:0] d);
      logic [CHAR_WIDTH-1:0] dx;
      dx = CHAR_WIDTH'(d);
      if (d < NIBBLE'(RADIX_DEC)) begin
         return CH_ZERO + dx;
      end else begin
         return CH_UPPER_A + dx - CHAR_WIDTH'(RADIX_DEC);
      end
   endfunction

endpackage

// ===== rtl/itoa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude, per-cycle digit extraction, digit store, output beat.
// ----------------------------------------------------------------------------
module itoa_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [itoa_pkg::IN_WIDTH-1:0]   req_value,
   input  logic                            req_hex_mode,
   input  itoa_pkg::itoa_cmd_type          cmd,
   output itoa_pkg::itoa_sts_type          sts,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [itoa_pkg::CHAR_WIDTH-1:0] rsp_ascii_char,
   output logic                            rsp_last,
   output logic [itoa_pkg::LEN_WIDTH-1:0]  rsp_text_length
);
   import itoa_pkg::*;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic                   hex_ff, hex_in;
   logic [NIBBLE-1:0]      dig_ff [DIGIT_MAX];
   logic [CNT_WIDTH-1:0]   wr_cnt_ff, wr_cnt_in;
   logic [IDX_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [LEN_WIDTH-1:0]   rsp_len_ff, rsp_len_in;

   logic [VALUE_WIDTH-1:0]   raw;
   logic [VALUE_WIDTH-1:0]   load_mag;
   logic [2*VALUE_WIDTH:0]   prod;
   logic [VALUE_WIDTH-1:0]   q_dec;
   logic [VALUE_WIDTH-1:0]   quot;
   logic [NIBBLE-1:0]        q10_lo;
   logic [NIBBLE-1:0]        digit;
   logic [NIBBLE-1:0]        rd_digit;
   logic                     rd_last;
   logic [LEN_WIDTH-1:0]     total;

   assign raw      = VALUE_WIDTH'($signed(req_value));
   assign load_mag = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

   assign prod   = mag_ff * DEC_RECIP;
   assign q_dec  = VALUE_WIDTH'(prod >> DEC_SHIFT);
   assign q10_lo = {q_dec[0], 3'b000} + {q_dec[2:0], 1'b0};
   assign quot   = hex_ff ? (mag_ff >> NIBBLE) : q_dec;
   assign digit  = hex_ff ? mag_ff[NIBBLE-1:0] : (mag_ff[NIBBLE-1:0] - q10_lo);

   assign rd_digit = dig_ff[rd_ptr_ff];
   assign rd_last  = (rd_ptr_ff == '0);
   assign total    = LEN_WIDTH'(wr_cnt_ff) + LEN_WIDTH'(neg_ff);

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      hex_in       = hex_ff;
      wr_cnt_in    = wr_cnt_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_len_in   = rsp_len_ff;
      if (cmd.load) begin
         mag_in    = load_mag;
         neg_in    = raw[VALUE_WIDTH-1];
         hex_in    = req_hex_mode;
         wr_cnt_in = '0;
      end
      if (cmd.step) begin
         mag_in    = quot;
         wr_cnt_in = wr_cnt_ff + CNT_WIDTH'(1);
         rd_ptr_in = wr_cnt_ff[IDX_WIDTH-1:0];
      end
      if (cmd.put_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CH_MINUS;
         rsp_last_in  = 1'b0;
         rsp_len_in   = '0;
      end
      if (cmd.put_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_to_ascii(rd_digit);
         rsp_last_in  = rd_last;
         rsp_len_in   = rd_last ? total : '0;
         if (!rd_last) begin
            rd_ptr_in = rd_ptr_ff - IDX_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         wr_cnt_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         wr_cnt_ff    <= wr_cnt_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      hex_ff      <= hex_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff  <= rsp_len_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         dig_ff[wr_cnt_ff[IDX_WIDTH-1:0]] <= digit;
      end
   end

   assign sts.conv_done  = (quot == '0);
   assign sts.negative   = neg_ff;
   assign sts.digit_last = rd_last;
   assign sts.out_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ascii_char  = rsp_char_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_text_length = rsp_len_ff;

   // no beat is dropped from the output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.put_sign || cmd.put_digit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output beat overwritten");

   a_one_put: assert property (@(posedge clock) disable iff (reset)
      !(cmd.put_sign && cmd.put_digit))
      else $error("sign and digit put together");

   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (wr_cnt_ff < CNT_WIDTH'(DIGIT_MAX)))
      else $error("digit store overflow");

   a_len_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_len_ff != '0))
      else $error("zero length on last beat");

   a_len_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (rsp_len_ff == '0))
      else $error("length on non-last beat");

endmodule

// ===== rtl/itoa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: accept, digit extraction loop, sign and digit emission.
// ----------------------------------------------------------------------------
module itoa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output itoa_pkg::itoa_cmd_type cmd,
   input  itoa_pkg::itoa_sts_type sts
);
   import itoa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (sts.conv_done) begin
               state_in = sts.negative ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.put_sign = 1'b1;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (sts.out_free) begin
               cmd.put_digit = 1'b1;
               if (sts.digit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == ST_IDLE && req_valid))
      else $error("load outside idle");

   a_sign_then_digit: assert property (@(posedge clock) disable iff (reset)
      cmd.put_sign |=> (state_ff == ST_DIGIT))
      else $error("sign not followed by digits");

   a_conv_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && sts.conv_done && !sts.negative) |=> (state_ff == ST_DIGIT))
      else $error("bad exit from conversion");

endmodule

// ===== rtl/int_to_ascii_dec_hex_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_ascii_dec_hex_core
// Signed integer to ASCII text, decimal or uppercase hex, one char per beat.
// ----------------------------------------------------------------------------
// Sequence: accept, then the divide-by-radix loop, which stores the digits least
//   significant first (one reciprocal multiply per cycle, or a nibble shift in hex),
//   then the sign if negative and the digits out, most significant first.
// No new request is taken until the last character is put out; a low rsp_ready delays it.
// Reset: synchronous, clears the controller and output valid; no clearing pass.
// ----------------------------------------------------------------------------
module int_to_ascii_dec_hex_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [itoa_pkg::IN_WIDTH-1:0]   req_value,
   input  logic                            req_hex_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [itoa_pkg::CHAR_WIDTH-1:0] rsp_ascii_char,
   output logic                            rsp_last,
   output logic [itoa_pkg::LEN_WIDTH-1:0]  rsp_text_length
);
   import itoa_pkg::*;

   itoa_cmd_type cmd;
   itoa_sts_type sts;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   itoa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_hex_mode    (req_hex_mode),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ascii_char  (rsp_ascii_char),
      .rsp_last        (rsp_last),
      .rsp_text_length (rsp_text_length)
   );

endmodule
